// File: hdl/ptri_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptri_pkg
// Shared types and codes for the polygon fan triangulator.
// ----------------------------------------------------------------------------
package ptri_pkg;

	localparam int unsigned WORD_W     = 16;
	localparam int unsigned TOTAL_W    = 32;
	localparam int unsigned QUEUE_AW   = 2;
	localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;
	localparam logic [WORD_W-1:0] MIN_VERTS = 16'd3;

	localparam logic [1:0] KIND_TRIANGLE = 2'd0;
	localparam logic [1:0] KIND_DONE     = 2'd1;
	localparam logic [1:0] KIND_ERROR    = 2'd2;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_POINT     = 2'd1;
	localparam logic [1:0] ERR_SURFACE   = 2'd2;
	localparam logic [1:0] ERR_CHUNK_END = 2'd3;

	localparam logic CFG_POINT_COUNT   = 1'b0;
	localparam logic CFG_SURFACE_COUNT = 1'b1;

	typedef enum logic [3:0] {
		PH_COUNT = 4'b0001,
		PH_INDEX = 4'b0010,
		PH_SURF  = 4'b0100,
		PH_DROP  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [WORD_W-1:0] vertex_a;
		logic [WORD_W-1:0] vertex_b;
		logic [WORD_W-1:0] vertex_c;
		logic [WORD_W-1:0] surface;
		logic [WORD_W-1:0] tri_count;
		logic [1:0]        error_code;
	} ptri_item_t;

endpackage
`default_nettype wire

// File: hdl/polygon_fan_triangulator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_fan_triangulator_top
// Assembles fan triangles from a stream of polygon words and keeps
// saturating triangle totals per surface.
// A result passes through the queue, the stage-one register and the result register before empty goes low.
// One word is accepted per cycle while full is low; the parse state updates on the edge that accepts the word.
// The totals memory does one read and one write per cycle.
// After reset a clearing pass zeroes every entry of the totals memory,
// with full held high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module polygon_fan_triangulator_top import ptri_pkg::*; #(
	parameter int unsigned MAX_SURFACES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [WORD_W-1:0]  word,
	input  wire logic               chunk_end,
	input  wire logic               pop,
	output logic                    empty,
	output logic [1:0]              kind,
	output logic [WORD_W-1:0]       vertex_a,
	output logic [WORD_W-1:0]       vertex_b,
	output logic [WORD_W-1:0]       vertex_c,
	output logic [7:0]              surface_index,
	output logic [WORD_W-1:0]       polygon_triangles,
	output logic [TOTAL_W-1:0]      surface_total,
	output logic [1:0]              error_code,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_data
);

	logic [15:0] point_count_q;
	logic [8:0]  surface_count_q;
	logic        accept;
	logic        item_valid;
	ptri_item_t  item;
	logic        q_full;
	logic        q_valid;
	logic        q_pop;
	ptri_item_t  q_item;
	logic        clearing;

	assign cfg_ready = 1'b1;
	assign full      = q_full || clearing;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q   <= '0;
			surface_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_POINT_COUNT:   point_count_q   <= cfg_data;
				CFG_SURFACE_COUNT: surface_count_q <= cfg_data[8:0];
				default:           point_count_q   <= point_count_q;
			endcase
		end
	end

	ptri_front #(
		.MAX_SURFACES(MAX_SURFACES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.word         (word),
		.chunk_end    (chunk_end),
		.point_count  (point_count_q),
		.surface_count(surface_count_q),
		.item_valid   (item_valid),
		.item         (item)
	);

	ptri_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (item_valid),
		.wr_item (item),
		.rd_en   (q_pop),
		.rd_valid(q_valid),
		.rd_item (q_item),
		.full    (q_full)
	);

	ptri_back #(
		.MAX_SURFACES(MAX_SURFACES)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.clearing         (clearing),
		.pop              (pop),
		.empty            (empty),
		.kind             (kind),
		.vertex_a         (vertex_a),
		.vertex_b         (vertex_b),
		.vertex_c         (vertex_c),
		.surface_index    (surface_index),
		.polygon_triangles(polygon_triangles),
		.surface_total    (surface_total),
		.error_code       (error_code)
	);

endmodule
`default_nettype wire

// File: hdl/ptri_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptri_front
// Parses the polygon word stream, checks indices and surfaces, and
// produces one classified item per word that causes a result.
// ----------------------------------------------------------------------------
module ptri_front import ptri_pkg::*; #(
	parameter int unsigned MAX_SURFACES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [WORD_W-1:0] word,
	input  wire logic              chunk_end,
	input  wire logic [15:0]       point_count,
	input  wire logic [8:0]        surface_count,
	output logic                   item_valid,
	output ptri_item_t             item
);

	phase_t            phase_q, phase_d;
	logic [WORD_W-1:0] left_q, left_d;
	logic [WORD_W-1:0] seen_q, seen_d;
	logic [WORD_W-1:0] first_q, first_d;
	logic [WORD_W-1:0] prev_q, prev_d;
	logic              degen_q, degen_d;
	logic              raise;
	logic [1:0]        raise_code;
	logic              bad_surface;

	assign bad_surface = (word == '0) || (word > {7'd0, surface_count})
		|| (word > WORD_W'(MAX_SURFACES));

	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		seen_d     = seen_q;
		first_d    = first_q;
		prev_d     = prev_q;
		degen_d    = degen_q;
		raise      = 1'b0;
		raise_code = ERR_NONE;
		item_valid = 1'b0;
		item       = '0;
		unique case (phase_q)
			PH_COUNT: begin
				left_d  = word;
				seen_d  = '0;
				first_d = '0;
				prev_d  = '0;
				degen_d = (word < MIN_VERTS);
				phase_d = (word == '0) ? PH_SURF : PH_INDEX;
				if (chunk_end) begin
					raise      = 1'b1;
					raise_code = ERR_CHUNK_END;
				end
			end
			PH_INDEX: begin
				if (!degen_q && (word >= point_count)) begin
					raise      = 1'b1;
					raise_code = ERR_POINT;
				end else begin
					if (!degen_q && (seen_q == '0)) begin
						first_d = word;
					end
					prev_d = word;
					seen_d = seen_q + 1'b1;
					left_d = left_q - 1'b1;
					if (left_d == '0) begin
						phase_d = PH_SURF;
					end
					if (chunk_end) begin
						raise      = 1'b1;
						raise_code = ERR_CHUNK_END;
					end else if (!degen_q && (seen_q >= 16'd2)) begin
						item_valid    = 1'b1;
						item.kind     = KIND_TRIANGLE;
						item.vertex_a = first_q;
						item.vertex_b = prev_q;
						item.vertex_c = word;
					end
				end
			end
			PH_SURF: begin
				phase_d = PH_COUNT;
				if (!degen_q) begin
					if (bad_surface) begin
						raise      = 1'b1;
						raise_code = ERR_SURFACE;
					end else begin
						item_valid     = 1'b1;
						item.kind      = KIND_DONE;
						item.surface   = word - 1'b1;
						item.tri_count = seen_q - 16'd2;
					end
				end
			end
			PH_DROP: begin
				if (chunk_end) begin
					phase_d = PH_COUNT;
				end
			end
			default: begin
				phase_d = PH_COUNT;
			end
		endcase
		if (raise) begin
			item_valid      = 1'b1;
			item            = '0;
			item.kind       = KIND_ERROR;
			item.error_code = raise_code;
			phase_d         = chunk_end ? PH_COUNT : PH_DROP;
		end
		if (!accept) begin
			item_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			left_q  <= '0;
			seen_q  <= '0;
			first_q <= '0;
			prev_q  <= '0;
			degen_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			seen_q  <= seen_d;
			first_q <= first_d;
			prev_q  <= prev_d;
			degen_q <= degen_d;
		end
	end

endmodule
`default_nettype wire

// File: hdl/ptri_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptri_queue
// Short first-in first-out queue of classified items between the front
// and back parts.
// ----------------------------------------------------------------------------
module ptri_queue import ptri_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire ptri_item_t wr_item,
	input  wire logic       rd_en,
	output logic            rd_valid,
	output ptri_item_t      rd_item,
	output logic            full
);

	ptri_item_t          entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign rd_valid = (count_q != '0);
	assign rd_item  = entry_q[rd_ptr_q];
	assign full     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/ptri_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptri_back
// Carries out queued items: updates the saturating per-surface totals in
// a memory and drives the result register.
// ----------------------------------------------------------------------------
module ptri_back import ptri_pkg::*; #(
	parameter int unsigned MAX_SURFACES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire ptri_item_t         q_item,
	output logic                    q_pop,
	output logic                    clearing,
	input  wire logic               pop,
	output logic                    empty,
	output logic [1:0]              kind,
	output logic [WORD_W-1:0]       vertex_a,
	output logic [WORD_W-1:0]       vertex_b,
	output logic [WORD_W-1:0]       vertex_c,
	output logic [7:0]              surface_index,
	output logic [WORD_W-1:0]       polygon_triangles,
	output logic [TOTAL_W-1:0]      surface_total,
	output logic [1:0]              error_code
);

	localparam int unsigned SW = (MAX_SURFACES > 1) ? $clog2(MAX_SURFACES) : 1;

	logic [TOTAL_W-1:0] totals_mem [MAX_SURFACES];
	logic               clr_q;
	logic [SW-1:0]      clr_idx_q;

	logic               valid_s1;
	ptri_item_t         item_s1;
	logic [TOTAL_W-1:0] total_s1;
	logic               adv_s1;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] sat_total;

	logic               out_valid_q;
	ptri_item_t         out_item_q;
	logic [TOTAL_W-1:0] out_total_q;

	assign clearing  = clr_q;
	assign empty     = !out_valid_q;
	assign adv_s1    = valid_s1 && (!out_valid_q || pop);
	assign q_pop     = q_valid && !clr_q && (!valid_s1 || adv_s1);
	assign sum       = {1'b0, total_s1} + {{(TOTAL_W-WORD_W+1){1'b0}}, item_s1.tri_count};
	assign sat_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

	always_ff @(posedge clk) begin
		if (clr_q) begin
			totals_mem[clr_idx_q] <= '0;
		end else if (adv_s1 && (item_s1.kind == KIND_DONE)) begin
			totals_mem[item_s1.surface[SW-1:0]] <= sat_total;
		end
		if (q_pop) begin
			total_s1 <= totals_mem[q_item.surface[SW-1:0]];
			item_s1  <= q_item;
		end
		if (adv_s1) begin
			out_item_q  <= item_s1;
			out_total_q <= (item_s1.kind == KIND_DONE) ? sat_total : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_idx_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == SW'(MAX_SURFACES - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign kind              = out_item_q.kind;
	assign vertex_a          = out_item_q.vertex_a;
	assign vertex_b          = out_item_q.vertex_b;
	assign vertex_c          = out_item_q.vertex_c;
	assign surface_index     = out_item_q.surface[7:0];
	assign polygon_triangles = out_item_q.tri_count;
	assign surface_total     = out_total_q;
	assign error_code        = out_item_q.error_code;

endmodule
`default_nettype wire
